/* design/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator.
// Holds the arena geometry, the request and result payloads and status codes.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ARENA_BYTES = 16384;
    localparam int HDR_BYTES   = 16;
    localparam int MAX_BLOCKS  = 64;

    localparam int AW = 14;                      // field width of offsets and sizes
    localparam int IW = $clog2(MAX_BLOCKS);      // table index width
    localparam int CW = $clog2(MAX_BLOCKS + 1);  // block count width
    // Internal offset and size width, wide enough for the whole arena.
    localparam int SW = $clog2(ARENA_BYTES + 1);

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic          kind;
        logic [AW-1:0] request_bytes;
        logic [AW-1:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] grant_addr;
        logic [AW-1:0] block_bytes;
    } t_rsp;

    // One block table entry: header offset, payload size and free flag.
    typedef struct packed {
        logic [SW-1:0] offset;
        logic [SW-1:0] size;
        logic          is_free;
    } t_blk;

endpackage

/* design/ffba_if.sv */
// ----------------------------------------------------------------------------
// ffba_req_if / ffba_rsp_if: valid-ready channels for requests and results.
// The source drives valid and payload, the sink drives ready.
// ----------------------------------------------------------------------------
interface ffba_req_if;
    import ffba_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ffba_rsp_if;
    import ffba_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/first_fit_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top: first-fit allocator over an ordered block list.
// An allocate reads each entry scanned, shifts the later entries up one place on
// a split, one read and one write each, and makes one or two table writes; a free
// scans alike, writes the entry, then re-reads each entry and on each merge writes
// the merged entry and shifts the later entries down. A new request is accepted only
// once the last result is taken. Reset loads one free block; entries past the count are never used.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top (
    input  logic i_clk,
    input  logic i_rst_n,
    ffba_req_if.sink   i_req,
    ffba_rsp_if.source o_rsp
);
    import ffba_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD    = 11'b00000000010,  // read request for entry r_i
        S_CHK   = 11'b00000000100,  // data of entry r_i available
        S_SHRD  = 11'b00000001000,  // shift: read entry r_k-1 (up) or r_k+1 (down)
        S_SHWR  = 11'b00000010000,  // shift: write entry r_k
        S_SPLIT = 11'b00000100000,  // write updated entry or split pair
        S_CRD   = 11'b00001000000,  // coalesce: read entry r_i
        S_CCHK  = 11'b00010000000,  // coalesce: compare pair
        S_CMRG  = 11'b00100000000,  // coalesce: write merged entry
        S_OUT   = 11'b01000000000,
        S_INIT  = 11'b10000000000
    } t_state;

    t_state r_state;
    t_blk   r_mem [MAX_BLOCKS];
    t_blk   r_rd;
    t_blk   r_cur, r_prev;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i, r_k;
    logic          r_dir;       // 1: shift up (split), 0: shift down (merge)
    logic          r_split;
    t_req          r_req;
    t_rsp          r_rsp;
    logic          r_have_prev;

    // Memory port signals.
    logic          we;
    logic [IW-1:0] waddr, raddr;
    t_blk          wdata;

    logic [SW-1:0] req_sz;
    assign req_sz = SW'(r_req.request_bytes);

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd <= r_mem[raddr];
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data  = r_rsp;

    // Memory access selection per state.
    always_comb begin
        we    = 1'b0;
        waddr = r_i[IW-1:0];
        raddr = r_i[IW-1:0];
        wdata = r_cur;
        unique case (r_state)
            S_INIT: begin
                we = 1'b1;
                waddr = '0;
                wdata = '{offset: '0, size: SW'(ARENA_BYTES - HDR_BYTES), is_free: 1'b1};
            end
            S_SHRD: raddr = r_dir ? IW'(r_k - 1'b1) : IW'(r_k + 1'b1);
            S_SHWR: begin
                we = 1'b1;
                waddr = r_k[IW-1:0];
                wdata = r_rd;
            end
            S_SPLIT: begin
                we = 1'b1;
                waddr = r_i[IW-1:0];
                wdata = r_cur;
            end
            S_CMRG: begin
                we = 1'b1;
                waddr = r_i[IW-1:0];
                wdata = r_prev;
            end
            S_CHK: begin
                // No table write while an entry is being checked.
                we = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CW'(1);
        end else begin
            unique case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: if (i_req.valid) begin
                    r_req   <= i_req.data;
                    r_i     <= '0;
                    r_split <= 1'b0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_i == r_count) begin
                        r_rsp <= '{status: (r_req.kind == KIND_ALLOC) ? ST_NO_FIT : ST_BAD,
                                   grant_addr: '0, block_bytes: '0};
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_cur <= r_rd;
                    r_state <= S_RD;
                    r_i <= r_i + 1'b1;
                    if (r_req.kind == KIND_ALLOC) begin
                        if (r_rd.is_free && r_rd.size == req_sz) begin
                            r_cur <= '{offset: r_rd.offset, size: r_rd.size, is_free: 1'b0};
                            r_i <= r_i;
                            r_split <= 1'b0;
                            r_rsp <= '{status: ST_DONE,
                                       grant_addr: AW'(r_rd.offset + SW'(HDR_BYTES)),
                                       block_bytes: AW'(r_rd.size)};
                            r_state <= S_SPLIT;
                        end else if (r_rd.is_free &&
                                     (SW+1)'(r_rd.size) > (SW+1)'(req_sz) + (SW+1)'(HDR_BYTES))
                        begin
                            r_i <= r_i;
                            if (r_count < CW'(MAX_BLOCKS)) begin
                                r_cur <= '{offset: r_rd.offset, size: req_sz, is_free: 1'b0};
                                r_prev <= '{offset: r_rd.offset + SW'(HDR_BYTES) + req_sz,
                                            size: r_rd.size - req_sz - SW'(HDR_BYTES),
                                            is_free: 1'b1};
                                r_split <= 1'b1;
                                r_dir <= 1'b1;
                                r_k <= r_count;
                                r_rsp <= '{status: ST_DONE,
                                           grant_addr: AW'(r_rd.offset + SW'(HDR_BYTES)),
                                           block_bytes: AW'(req_sz)};
                                r_state <= (r_count > r_i + 1'b1) ? S_SHRD : S_SPLIT;
                            end else begin
                                r_cur <= '{offset: r_rd.offset, size: r_rd.size, is_free: 1'b0};
                                r_split <= 1'b0;
                                r_rsp <= '{status: ST_DONE,
                                           grant_addr: AW'(r_rd.offset + SW'(HDR_BYTES)),
                                           block_bytes: AW'(r_rd.size)};
                                r_state <= S_SPLIT;
                            end
                        end
                    end else if (!r_rd.is_free &&
                                 AW'(r_rd.offset + SW'(HDR_BYTES)) == r_req.free_addr) begin
                        r_i <= r_i;
                        r_cur <= '{offset: r_rd.offset, size: r_rd.size, is_free: 1'b1};
                        r_split <= 1'b0;
                        r_rsp <= '{status: ST_DONE, grant_addr: '0,
                                   block_bytes: AW'(r_rd.size)};
                        r_state <= S_SPLIT;
                    end
                end
                // Shift entries by one place, one entry per read/write pair.
                S_SHRD: r_state <= S_SHWR;
                S_SHWR: begin
                    if (r_dir) begin
                        r_k <= r_k - 1'b1;
                        r_state <= (r_k - 1'b1 > r_i + 1'b1) ? S_SHRD : S_SPLIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                        if (r_k + 2'd2 < r_count) r_state <= S_SHRD;
                        else begin
                            r_count <= r_count - 1'b1;
                            r_state <= S_CRD;
                        end
                    end
                end
                // Write the updated entry; on a split, then write the remainder.
                S_SPLIT: begin
                    if (r_split) begin
                        r_split <= 1'b0;
                        r_cur <= r_prev;
                        r_i <= r_i + 1'b1;
                        r_count <= r_count + 1'b1;
                        r_state <= S_SPLIT;
                    end else if (r_req.kind == KIND_FREE) begin
                        r_i <= '0;
                        r_have_prev <= 1'b0;
                        r_state <= S_CRD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                // Coalescing pass: hold entry i in r_prev, compare with i+1.
                S_CRD: begin
                    if (r_i == r_count) r_state <= S_OUT;
                    else r_state <= S_CCHK;
                end
                S_CCHK: begin
                    if (r_have_prev && r_prev.is_free && r_rd.is_free) begin
                        r_prev.size <= r_prev.size + r_rd.size + SW'(HDR_BYTES);
                        r_i <= r_i - 1'b1;
                        r_state <= S_CMRG;
                    end else begin
                        r_prev <= r_rd;
                        r_have_prev <= 1'b1;
                        r_i <= r_i + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_CMRG: begin
                    // r_i points at merged entry; remove entry r_i+1 by shift.
                    r_dir <= 1'b0;
                    r_k <= r_i + 1'b1;
                    if (r_i + 2'd2 < r_count) begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SHRD;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_i <= r_i + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_OUT: if (o_rsp.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
